// ----- sv/bilinear_plane_resampler_top_assert.svh -----
// assertion macros shared by the plane and blend modules
`ifndef BILINEAR_PLANE_RESAMPLER_TOP_ASSERT_SVH
`define BILINEAR_PLANE_RESAMPLER_TOP_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define BPR_ASSERT_IMP(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("bpr assertion failed");
// next-cycle implication
`define BPR_ASSERT_NEXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("bpr assertion failed");
`else
`define BPR_ASSERT_IMP(name, pre, post)
`define BPR_ASSERT_NEXT(name, pre, post)
`endif
`endif

// ----- sv/bpr_pkg.sv -----
// shared constants and types for the bilinear plane resampler
`timescale 1ns / 1ps
package bpr_pkg;
	localparam int MAX_SRC_WIDTH    = 256;
	localparam int MAX_SRC_HEIGHT   = 256;
	localparam int WEIGHT_FRAC_BITS = 12;
	localparam int MAX_DST          = 4096;
	localparam int RESET_SIZE       = 256;

	localparam int MAX_SRC  = (MAX_SRC_WIDTH > MAX_SRC_HEIGHT) ? MAX_SRC_WIDTH : MAX_SRC_HEIGHT;
	localparam int COL_W    = $clog2(MAX_SRC_WIDTH);
	localparam int ROW_W    = $clog2(MAX_SRC_HEIGHT);
	localparam int IDX_W    = $clog2(MAX_SRC);
	localparam int ADDR_W   = COL_W + ROW_W;
	localparam int PLANE_DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;

	// field and register widths
	localparam int COORD_W   = 12;
	localparam int SAMPLE_W  = 16;
	localparam int SRC_REG_W = 9;
	localparam int DST_REG_W = 13;
	localparam int SRC_SZ_W  = $clog2(MAX_SRC + 1);
	localparam int DST_SZ_W  = $clog2(MAX_DST + 1);

	// weights
	localparam int WFB   = WEIGHT_FRAC_BITS;
	localparam int WGT_W = WFB + 1;
	localparam logic [WGT_W-1:0] W_ONE = WGT_W'(1 << WFB);

	// coordinate divider
	localparam int PROD_W     = COORD_W + 1 + SRC_SZ_W;
	localparam int DEN_W      = DST_SZ_W + 1;
	localparam int QW         = IDX_W + WFB + 1;
	localparam int DIV_STEP   = 3;
	localparam int DIV_STAGES = (QW + DIV_STEP - 1) / DIV_STEP;
	localparam int DIV_W      = DIV_STAGES * DIV_STEP;

	// result queue
	localparam int FIFO_DEPTH = 8;
	localparam int FD_W       = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	// codes
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;
	localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
	localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
	localparam logic [1:0] REG_DST_WIDTH  = 2'd2;
	localparam logic [1:0] REG_DST_HEIGHT = 2'd3;
	localparam logic [1:0] BEAT_LAST      = 2'd3;

	typedef struct packed {
		logic [SRC_SZ_W-1:0] sw;
		logic [SRC_SZ_W-1:0] sh;
		logic [DST_SZ_W-1:0] dw;
		logic [DST_SZ_W-1:0] dh;
	} size_t;

	typedef struct packed {
		logic                op;
		logic                bad;
		logic                ld_ok;
		logic [COL_W-1:0]    ld_col;
		logic [ROW_W-1:0]    ld_row;
		logic [SAMPLE_W-1:0] sample;
	} item_meta_t;

	typedef struct packed {
		item_meta_t       meta;
		logic [IDX_W-1:0] x0;
		logic [IDX_W-1:0] x1;
		logic [IDX_W-1:0] y0;
		logic [IDX_W-1:0] y1;
		logic [WFB-1:0]   wx;
		logic [WFB-1:0]   wy;
	} coord_t;

	typedef struct packed {
		logic           valid;
		logic [1:0]     k;
		logic           bad;
		logic [WFB-1:0] wx;
		logic [WFB-1:0] wy;
	} beat_ctl_t;

	typedef struct packed {
		beat_ctl_t                   ctl;
		logic signed [SAMPLE_W-1:0]  sample;
	} beat_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] value;
		logic                bad;
	} res_t;
endpackage

// ----- sv/bpr_ifs.sv -----
// request and result channel interfaces
`timescale 1ns / 1ps
interface bpr_in_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 op;
	logic [bpr_pkg::COORD_W-1:0]          col;
	logic [bpr_pkg::COORD_W-1:0]          row;
	logic signed [bpr_pkg::SAMPLE_W-1:0]  sample_in;
	modport source (output valid, op, col, row, sample_in, input ready);
	modport sink (input valid, op, col, row, sample_in, output ready);
endinterface

interface bpr_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [bpr_pkg::SAMPLE_W-1:0]  out_value;
	logic                                 bad_coordinate;
	modport source (output valid, out_value, bad_coordinate, input ready);
	modport sink (input valid, out_value, bad_coordinate, output ready);
endinterface

// ----- sv/bpr_coord.sv -----
// coordinate pipeline: source position, pipelined divider, neighbor indices and weights
`timescale 1ns / 1ps
module bpr_coord (
	input  logic            clk,
	input  logic            arst_n,
	input  bpr_pkg::size_t  sizes,
	bpr_in_if.sink          in_ch,
	output logic            c_valid,
	output bpr_pkg::coord_t c_item,
	input  logic            c_take
);
	import bpr_pkg::*;

	localparam int NB_W = DEN_W + DIV_W;

	typedef struct packed {
		logic [DEN_W-1:0] rem;
		logic [DIV_W-1:0] low;
		logic [DIV_W-1:0] quo;
	} div_t;

	typedef struct packed {
		logic [IDX_W-1:0] i0;
		logic [IDX_W-1:0] i1;
		logic [WFB-1:0]   w;
	} axis_t;

	// numerator (2d+1)*s-n clamped at zero, scaled by the weight step, plus n for rounding
	function automatic div_t div_init(logic [PROD_W-1:0] prod, logic [DST_SZ_W-1:0] n);
		logic [PROD_W-1:0] num;
		logic [NB_W-1:0]   big;
		div_t              r;
		num = (prod > PROD_W'(n)) ? prod - PROD_W'(n) : '0;
		big = (NB_W'(num) << WFB) + NB_W'(n);
		r.rem = big[NB_W-1 -: DEN_W];
		r.low = big[DIV_W-1:0];
		r.quo = '0;
		return r;
	endfunction

	// a few restoring division steps
	function automatic div_t div_steps(div_t d, logic [DEN_W-1:0] den);
		div_t           r;
		logic [DEN_W:0] t;
		r = d;
		for (int i = 0; i < DIV_STEP; i++) begin
			t = {r.rem, r.low[DIV_W-1]};
			r.low = r.low << 1;
			if (t >= {1'b0, den}) begin
				t = t - {1'b0, den};
				r.quo = {r.quo[DIV_W-2:0], 1'b1};
			end else begin
				r.quo = {r.quo[DIV_W-2:0], 1'b0};
			end
			r.rem = t[DEN_W-1:0];
		end
		return r;
	endfunction

	// quotient to clamped neighbor pair and fractional weight
	function automatic axis_t idx_map(logic [DIV_W-1:0] quo, logic [SRC_SZ_W-1:0] s);
		logic [DIV_W-WFB-1:0] i0w;
		logic [SRC_SZ_W-1:0]  lastv;
		logic [SRC_SZ_W-1:0]  i0;
		logic [SRC_SZ_W-1:0]  i1n;
		axis_t                a;
		lastv = s - 1'b1;
		i0w   = quo[DIV_W-1:WFB];
		i0    = (i0w > (DIV_W-WFB)'(lastv)) ? lastv : SRC_SZ_W'(i0w);
		i1n   = i0 + 1'b1;
		a.i0  = i0[IDX_W-1:0];
		a.i1  = (i1n < s) ? i1n[IDX_W-1:0] : lastv[IDX_W-1:0];
		a.w   = quo[WFB-1:0];
		return a;
	endfunction

	logic                adv;
	logic                v_s1;
	item_meta_t          meta_s1;
	logic [PROD_W-1:0]   prx_s1;
	logic [PROD_W-1:0]   pry_s1;
	logic                dv_v_q [DIV_STAGES+1];
	item_meta_t          dv_meta_q [DIV_STAGES+1];
	div_t                dvx_q [DIV_STAGES+1];
	div_t                dvy_q [DIV_STAGES+1];
	logic                c_v_q;
	coord_t              c_item_q;
	item_meta_t          in_meta;
	logic [DEN_W-1:0]    den_x;
	logic [DEN_W-1:0]    den_y;
	axis_t               ax;
	axis_t               ay;

	// whole pipeline moves together when the tail is free
	assign adv         = !c_v_q || c_take;
	assign in_ch.ready = adv;
	assign c_valid     = c_v_q;
	assign c_item      = c_item_q;

	assign den_x = {sizes.dw, 1'b0};
	assign den_y = {sizes.dh, 1'b0};

	// request classification
	always_comb begin
		in_meta.op     = in_ch.op;
		in_meta.bad    = (in_ch.op == OP_QUERY) &&
			((DST_SZ_W'(in_ch.col) >= sizes.dw) || (DST_SZ_W'(in_ch.row) >= sizes.dh));
		in_meta.ld_ok  = (in_ch.col < COORD_W'(sizes.sw)) && (in_ch.row < COORD_W'(sizes.sh));
		in_meta.ld_col = in_ch.col[COL_W-1:0];
		in_meta.ld_row = in_ch.row[ROW_W-1:0];
		in_meta.sample = in_ch.sample_in;
	end

	assign ax = idx_map(dvx_q[DIV_STAGES].quo, sizes.sw);
	assign ay = idx_map(dvy_q[DIV_STAGES].quo, sizes.sh);

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			c_v_q <= 1'b0;
			for (int j = 0; j <= DIV_STAGES; j++) dv_v_q[j] <= 1'b0;
		end else if (adv) begin
			v_s1      <= in_ch.valid;
			dv_v_q[0] <= v_s1;
			for (int j = 1; j <= DIV_STAGES; j++) dv_v_q[j] <= dv_v_q[j-1];
			c_v_q     <= dv_v_q[DIV_STAGES];
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s1      <= in_meta;
			prx_s1       <= PROD_W'({in_ch.col, 1'b1}) * PROD_W'(sizes.sw);
			pry_s1       <= PROD_W'({in_ch.row, 1'b1}) * PROD_W'(sizes.sh);
			dv_meta_q[0] <= meta_s1;
			dvx_q[0]     <= div_init(prx_s1, sizes.dw);
			dvy_q[0]     <= div_init(pry_s1, sizes.dh);
			for (int j = 1; j <= DIV_STAGES; j++) begin
				dv_meta_q[j] <= dv_meta_q[j-1];
				dvx_q[j]     <= div_steps(dvx_q[j-1], den_x);
				dvy_q[j]     <= div_steps(dvy_q[j-1], den_y);
			end
			c_item_q.meta <= dv_meta_q[DIV_STAGES];
			c_item_q.x0   <= ax.i0;
			c_item_q.x1   <= ax.i1;
			c_item_q.wx   <= ax.w;
			c_item_q.y0   <= ay.i0;
			c_item_q.y1   <= ay.i1;
			c_item_q.wy   <= ay.w;
		end
	end
endmodule

// ----- sv/bpr_plane.sv -----
// plane memory with the load and four-read fetch sequencer
`timescale 1ns / 1ps
module bpr_plane (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            c_valid,
	input  bpr_pkg::coord_t c_item,
	output logic            c_take,
	input  logic            room,
	output logic            start,
	output bpr_pkg::beat_t  beat
);
	import bpr_pkg::*;
	`include "bilinear_plane_resampler_top_assert.svh"

	logic [SAMPLE_W-1:0] mem [PLANE_DEPTH];
	logic                busy_q;
	logic [1:0]          k_q;
	coord_t              cur_q;
	logic                last;
	logic                wr_en;
	logic                rd_en;
	logic [COL_W-1:0]    rcol;
	logic [ROW_W-1:0]    rrow;
	logic [ADDR_W-1:0]   addr;
	logic [SAMPLE_W-1:0] rdata_q;
	logic                bv_q;
	beat_ctl_t           bctl_q;

	// a load or a bad query ends with its first busy step, a good query with its fourth read
	assign last = busy_q && ((cur_q.meta.op == OP_LOAD) || cur_q.meta.bad ||
		(k_q == BEAT_LAST));
	assign c_take = c_valid && (!busy_q || last) && ((c_item.meta.op == OP_LOAD) || room);
	assign start  = c_take && (c_item.meta.op == OP_QUERY);

	assign wr_en = busy_q && (cur_q.meta.op == OP_LOAD) && cur_q.meta.ld_ok;
	assign rd_en = busy_q && (cur_q.meta.op == OP_QUERY) && !cur_q.meta.bad;

	// read order: (y0,x0) (y0,x1) (y1,x0) (y1,x1)
	assign rcol = k_q[0] ? cur_q.x1[COL_W-1:0] : cur_q.x0[COL_W-1:0];
	assign rrow = k_q[1] ? cur_q.y1[ROW_W-1:0] : cur_q.y0[ROW_W-1:0];
	assign addr = wr_en ? {cur_q.meta.ld_row, cur_q.meta.ld_col} : {rrow, rcol};

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q    <= '0;
		end else if (c_take) begin
			busy_q <= 1'b1;
			k_q    <= '0;
		end else if (last) begin
			busy_q <= 1'b0;
		end else if (busy_q) begin
			k_q <= k_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (c_take) cur_q <= c_item;
	end

	// single-port plane store
	always_ff @(posedge clk) begin
		if (wr_en) mem[addr] <= cur_q.meta.sample;
		rdata_q <= mem[addr];
	end

	// beat tag, aligned with the read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) bv_q <= 1'b0;
		else bv_q <= busy_q && (cur_q.meta.op == OP_QUERY);
	end

	always_ff @(posedge clk) begin
		bctl_q.valid <= 1'b0;
		bctl_q.k     <= cur_q.meta.bad ? BEAT_LAST : k_q;
		bctl_q.bad   <= cur_q.meta.bad;
		bctl_q.wx    <= cur_q.wx;
		bctl_q.wy    <= cur_q.wy;
	end

	always_comb begin
		beat.ctl       = bctl_q;
		beat.ctl.valid = bv_q;
		beat.sample    = rdata_q;
	end

	`BPR_ASSERT_NEXT(a_read_seq, rd_en && (k_q != BEAT_LAST), rd_en && (k_q == $past(k_q) + 2'd1))
	`BPR_ASSERT_NEXT(a_read_beat, rd_en, beat.ctl.valid && !beat.ctl.bad)
	`BPR_ASSERT_IMP(a_port_excl, wr_en, !rd_en && !beat.ctl.valid || !rd_en)
endmodule

// ----- sv/bpr_blend.sv -----
// blend pipeline, rounding and saturation, and the result queue
`timescale 1ns / 1ps
module bpr_blend (
	input  logic           clk,
	input  logic           arst_n,
	input  bpr_pkg::beat_t beat,
	input  logic           start,
	output logic           room,
	bpr_out_if.source      out_ch
);
	import bpr_pkg::*;
	`include "bilinear_plane_resampler_top_assert.svh"

	localparam int H_W = SAMPLE_W + WGT_W + 1;
	localparam int M_W = H_W + WGT_W + 1;
	localparam int T_W = M_W + 2;
	localparam int RS  = 2 * WFB;
	localparam logic signed [T_W-1:0] RND_BIAS =
		(T_W'(1) << (SAMPLE_W - 1 + RS)) + (T_W'(1) << (RS - 1));
	localparam logic [SAMPLE_W-1:0] SAT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic [SAMPLE_W-1:0] SAT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

	logic [WGT_W-1:0]       hw;
	logic signed [WGT_W:0]  hws;
	logic signed [H_W-1:0]  p_c;
	logic                   v_s1;
	logic [1:0]             k_s1;
	logic                   bad_s1;
	logic [WFB-1:0]         wy_s1;
	logic signed [H_W-1:0]  p_s1;
	logic signed [H_W-1:0]  acc_q;
	logic                   v_s2;
	logic                   k1_s2;
	logic                   bad_s2;
	logic [WFB-1:0]         wy_s2;
	logic signed [H_W-1:0]  h_s2;
	logic [WGT_W-1:0]       vw;
	logic signed [WGT_W:0]  vws;
	logic                   v_s3;
	logic                   k1_s3;
	logic                   bad_s3;
	logic signed [M_W-1:0]  m_s3;
	logic signed [M_W-1:0]  acc2_q;
	logic signed [T_W-1:0]  t_c;
	logic [SAMPLE_W-1:0]    sat_c;
	res_t                   res_c;
	logic                   push;
	logic                   pop;
	res_t                   fifo_q [FIFO_DEPTH];
	logic [FD_W-1:0]        wp_q;
	logic [FD_W-1:0]        rp_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [CNT_W-1:0]       crd_q;

	// horizontal weight product
	assign hw  = beat.ctl.k[0] ? WGT_W'(beat.ctl.wx) : W_ONE - WGT_W'(beat.ctl.wx);
	assign hws = {1'b0, hw};
	assign p_c = beat.sample * hws;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= beat.ctl.valid;
			v_s2 <= v_s1 && (k_s1[0] || bad_s1);
			v_s3 <= v_s2;
		end
	end

	// vertical weight
	assign vw  = k1_s2 ? WGT_W'(wy_s2) : W_ONE - WGT_W'(wy_s2);
	assign vws = {1'b0, vw};

	always_ff @(posedge clk) begin
		k_s1   <= beat.ctl.k;
		bad_s1 <= beat.ctl.bad;
		wy_s1  <= beat.ctl.wy;
		p_s1   <= p_c;
		// row sum of two horizontal products
		if (v_s1 && !k_s1[0]) acc_q <= p_s1;
		h_s2   <= acc_q + p_s1;
		k1_s2  <= k_s1[1];
		bad_s2 <= bad_s1;
		wy_s2  <= wy_s1;
		m_s3   <= M_W'(h_s2) * M_W'(vws);
		k1_s3  <= k1_s2;
		bad_s3 <= bad_s2;
		if (v_s3 && !k1_s3) acc2_q <= m_s3;
	end

	// final sum, round half up and saturate
	assign t_c = T_W'(acc2_q) + T_W'(m_s3) + RND_BIAS;
	always_comb begin
		if (t_c[T_W-1]) sat_c = SAT_MIN;
		else if (|t_c[T_W-2:RS+SAMPLE_W]) sat_c = SAT_MAX;
		else sat_c = {~t_c[RS+SAMPLE_W-1], t_c[RS+SAMPLE_W-2:RS]};
		res_c.value = bad_s3 ? '0 : sat_c;
		res_c.bad   = bad_s3;
	end

	assign push = v_s3 && (k1_s3 || bad_s3);
	assign pop  = out_ch.valid && out_ch.ready;

	// result queue
	always_ff @(posedge clk) begin
		if (push) fifo_q[wp_q] <= res_c;
	end

	assign out_ch.valid          = (cnt_q != '0);
	assign out_ch.out_value      = fifo_q[rp_q].value;
	assign out_ch.bad_coordinate = fifo_q[rp_q].bad;

	// queue pointers and reserved slots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
			crd_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
			if (start && !pop) crd_q <= crd_q + 1'b1;
			else if (pop && !start) crd_q <= crd_q - 1'b1;
		end
	end

	assign room = (crd_q < CNT_W'(FIFO_DEPTH));

	`BPR_ASSERT_IMP(a_fifo_in_credit, 1'b1, cnt_q <= crd_q)
	`BPR_ASSERT_IMP(a_no_overflow, push, (cnt_q < CNT_W'(FIFO_DEPTH)) || pop)
	`BPR_ASSERT_IMP(a_credit_full, crd_q == CNT_W'(FIFO_DEPTH), !start)
endmodule

// ----- sv/bilinear_plane_resampler_top.sv -----
// Bilinear plane resampler: load requests fill the plane store, query requests resample it.
// A query reads four samples, one per read on the single-port plane memory; a load writes one
// sample and a query outside the destination reads none. Requests flow in while earlier ones
// are still in flight, unless the pipeline tail or the result queue holds them back.
// Reset: size registers return to 256 and all pipeline and queue control clears; the plane
// store is not cleared and holds undefined data until written.
`timescale 1ns / 1ps
module bilinear_plane_resampler_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	bpr_in_if.sink      in_ch,
	bpr_out_if.source   out_ch
);
	import bpr_pkg::*;

	logic [SRC_REG_W-1:0] src_w_q;
	logic [SRC_REG_W-1:0] src_h_q;
	logic [DST_REG_W-1:0] dst_w_q;
	logic [DST_REG_W-1:0] dst_h_q;
	logic                 wr;
	size_t                sizes;
	logic                 c_valid;
	coord_t               c_item;
	logic                 c_take;
	logic                 room;
	logic                 start;
	beat_t                beat;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= SRC_REG_W'(RESET_SIZE);
			src_h_q <= SRC_REG_W'(RESET_SIZE);
			dst_w_q <= DST_REG_W'(RESET_SIZE);
			dst_h_q <= DST_REG_W'(RESET_SIZE);
		end else if (wr) begin
			unique case (paddr[3:2])
				REG_SRC_WIDTH: src_w_q <= pwdata[SRC_REG_W-1:0];
				REG_SRC_HEIGHT: src_h_q <= pwdata[SRC_REG_W-1:0];
				REG_DST_WIDTH: dst_w_q <= pwdata[DST_REG_W-1:0];
				REG_DST_HEIGHT: dst_h_q <= pwdata[DST_REG_W-1:0];
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (paddr[3:2])
			REG_SRC_WIDTH: prdata = 32'(src_w_q);
			REG_SRC_HEIGHT: prdata = 32'(src_h_q);
			REG_DST_WIDTH: prdata = 32'(dst_w_q);
			REG_DST_HEIGHT: prdata = 32'(dst_h_q);
		endcase
	end

	// effective sizes: zero acts as one, oversize acts as the maximum
	always_comb begin
		if (src_w_q == '0) sizes.sw = SRC_SZ_W'(1);
		else if (src_w_q > SRC_REG_W'(MAX_SRC_WIDTH)) sizes.sw = SRC_SZ_W'(MAX_SRC_WIDTH);
		else sizes.sw = SRC_SZ_W'(src_w_q);
		if (src_h_q == '0) sizes.sh = SRC_SZ_W'(1);
		else if (src_h_q > SRC_REG_W'(MAX_SRC_HEIGHT)) sizes.sh = SRC_SZ_W'(MAX_SRC_HEIGHT);
		else sizes.sh = SRC_SZ_W'(src_h_q);
		if (dst_w_q == '0) sizes.dw = DST_SZ_W'(1);
		else if (dst_w_q > DST_REG_W'(MAX_DST)) sizes.dw = DST_SZ_W'(MAX_DST);
		else sizes.dw = DST_SZ_W'(dst_w_q);
		if (dst_h_q == '0) sizes.dh = DST_SZ_W'(1);
		else if (dst_h_q > DST_REG_W'(MAX_DST)) sizes.dh = DST_SZ_W'(MAX_DST);
		else sizes.dh = DST_SZ_W'(dst_h_q);
	end

	bpr_coord u_coord (
		.clk     (clk),
		.arst_n  (arst_n),
		.sizes   (sizes),
		.in_ch   (in_ch),
		.c_valid (c_valid),
		.c_item  (c_item),
		.c_take  (c_take)
	);

	bpr_plane u_plane (
		.clk     (clk),
		.arst_n  (arst_n),
		.c_valid (c_valid),
		.c_item  (c_item),
		.c_take  (c_take),
		.room    (room),
		.start   (start),
		.beat    (beat)
	);

	bpr_blend u_blend (
		.clk    (clk),
		.arst_n (arst_n),
		.beat   (beat),
		.start  (start),
		.room   (room),
		.out_ch (out_ch)
	);
endmodule
